/* design/bag_vertex_membership_table_assert.svh */
// Assertion helpers for the membership table; clk_i and rst_ni are taken from the enclosing scope.
`ifndef BAG_VERTEX_MEMBERSHIP_TABLE_ASSERT_SVH
`define BAG_VERTEX_MEMBERSHIP_TABLE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define BVMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true outside reset
`define BVMT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* design/bvmt_pkg.sv */
package bvmt_pkg;

  // Field widths of the channels
  localparam int OPCODE_W    = 3;
  localparam int BAG_IDX_W   = 6;
  localparam int VTX_IDX_W   = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int CNT_OUT_W   = 7;
  localparam int TOTAL_OUT_W = 13;

  // Saturation limits of the reported counts
  localparam int CNT_SAT   = 127;
  localparam int TOTAL_SAT = 8191;

  // Default store sizes
  localparam int DEF_MAX_BAGS     = 64;
  localparam int DEF_MAX_VERTICES = 64;

  // Size registers after reset
  localparam logic [CFG_DATA_W-1:0] CFG_RESET = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAGS_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICES_IN_USE = 2'd1;

  // Row popcount is done this many bits per cycle
  localparam int POP_CHUNK = 8;
  localparam int POP_W     = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_QUERY   = 3'd2,
    OP_CLR_BAG = 3'd3,
    OP_CLR_ALL = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CLR,
    S_WAIT,
    S_DONE
  } state_e;

  function automatic logic [POP_W-1:0] popcount_chunk(input logic [POP_CHUNK-1:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < POP_CHUNK; i++) begin
      n = n + POP_W'(x[i]);
    end
    return n;
  endfunction

endpackage

/* design/bvmt_if.sv */
// Operation channel
interface bvmt_in_if;
  import bvmt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [BAG_IDX_W-1:0] bag_index;
  logic [VTX_IDX_W-1:0] vertex_index;

  modport source (output valid, opcode, bag_index, vertex_index, input ready);
  modport sink   (input valid, opcode, bag_index, vertex_index, output ready);
endinterface

// Result channel
interface bvmt_out_if;
  import bvmt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   member;
  logic [CNT_OUT_W-1:0]   vertex_bag_count;
  logic                   bag_empty;
  logic [TOTAL_OUT_W-1:0] total_used;
  logic [CNT_OUT_W-1:0]   max_bag_count;
  logic                   valid_res;
  logic                   index_error;

  modport source (output valid, member, vertex_bag_count, bag_empty, total_used,
                  max_bag_count, valid_res, index_error, input ready);
  modport sink   (input valid, member, vertex_bag_count, bag_empty, total_used,
                  max_bag_count, valid_res, index_error, output ready);
endinterface

// Register write channel
interface bvmt_cfg_if;
  import bvmt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/bvmt_ram.sv */
module bvmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bvmt_max_tree.sv */
module bvmt_max_tree #(
  parameter int N  = bvmt_pkg::DEF_MAX_VERTICES,
  parameter int CW = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [CW-1:0]                    counts_i [N],
  input  logic [bvmt_pkg::CFG_DATA_W-1:0]  limit_i,
  output logic [bvmt_pkg::CNT_OUT_W-1:0]   max_o
);

  import bvmt_pkg::*;

  localparam int NP    = 1 << $clog2(N);
  localparam int NODES = 2 * NP - 1;

  logic [CNT_OUT_W-1:0] node_q [NODES];
  logic [CNT_OUT_W-1:0] node_d [NODES];

  // One tree level per cycle; leaves take the saturated counts of vertices in use
  always_comb begin
    for (int i = 0; i < NP - 1; i++) begin
      node_d[i] = (node_q[2*i+1] > node_q[2*i+2]) ? node_q[2*i+1] : node_q[2*i+2];
    end
    for (int j = 0; j < N; j++) begin
      if (j < int'(limit_i)) begin
        node_d[NP-1+j] = (int'(counts_i[j]) > CNT_SAT) ? CNT_OUT_W'(CNT_SAT)
                                                       : CNT_OUT_W'(counts_i[j]);
      end else begin
        node_d[NP-1+j] = '0;
      end
    end
    // padding leaves
    for (int j = N; j < NP; j++) begin
      node_d[NP-1+j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        node_q[i] <= '0;
      end
    end else begin
      node_q <= node_d;
    end
  end

  assign max_o = node_q[0];

endmodule

/* design/bag_vertex_membership_table.sv */
// Flow: an input transfer registers the item and reads its row; the modify state then updates
//   row, counts and total; clear bag adds the 8-bit-per-cycle popcount of the row for the total;
//   the item then waits on the registered max tree over vertex counts before the result loads.
// Throughput: one item in flight; next input taken the cycle after the result register loads.
// Reset: row valid bits, vertex counts and total clear at once (no pass over the memory);
//   bags_in_use and vertices_in_use reset to 64.
`include "bag_vertex_membership_table_assert.svh"

module bag_vertex_membership_table #(
  parameter int MAX_BAGS     = bvmt_pkg::DEF_MAX_BAGS,
  parameter int MAX_VERTICES = bvmt_pkg::DEF_MAX_VERTICES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bvmt_cfg_if.sink          cfg_i,
  bvmt_in_if.sink           in_i,
  bvmt_out_if.source        out_o
);

  import bvmt_pkg::*;

  localparam int ROW_W    = MAX_VERTICES;
  localparam int BAG_AW   = $clog2(MAX_BAGS);
  localparam int VTX_AW   = $clog2(MAX_VERTICES);
  localparam int CNT_W    = $clog2(MAX_BAGS + 1);
  localparam int TOT_W    = $clog2(MAX_BAGS * MAX_VERTICES + 1);
  localparam int TREE_LVL = $clog2(MAX_VERTICES);
  localparam int WAIT_W   = $clog2(TREE_LVL + 1);
  localparam int NCHUNK   = (MAX_VERTICES + POP_CHUNK - 1) / POP_CHUNK;
  localparam int CHK_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int ROW_PW   = NCHUNK * POP_CHUNK;

  function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c);
    return (int'(c) > CNT_SAT) ? CNT_OUT_W'(CNT_SAT) : CNT_OUT_W'(c);
  endfunction

  // Control state
  state_e                state_q, state_d;
  logic [CFG_DATA_W-1:0] bags_q, verts_q;
  logic [MAX_BAGS-1:0]   valid_q, valid_d;
  logic [CNT_W-1:0]      counts_q [MAX_VERTICES];
  logic [CNT_W-1:0]      counts_d [MAX_VERTICES];
  logic [TOT_W-1:0]      total_q, total_d;
  logic [WAIT_W-1:0]     wcnt_q;
  logic [CHK_W-1:0]      chunk_q;
  logic                  out_valid_q;

  // Item and result payload
  logic [OPCODE_W-1:0]   op_q;
  logic [BAG_IDX_W-1:0]  b_q;
  logic [VTX_IDX_W-1:0]  v_q;
  logic [ROW_PW-1:0]     row_q;
  logic                  res_member_q, res_member_d;
  logic [CNT_W-1:0]      res_cnt_d;
  logic [CNT_OUT_W-1:0]  res_cnt_q;
  logic                  res_empty_q, res_empty_d;
  logic                  res_err_q, res_err_d;

  // FSM outputs
  logic in_ready, ram_re, is_mod, is_clr, is_wait, is_done, out_free, out_load;

  // Datapath
  logic [BAG_AW-1:0]    b_idx;
  logic [VTX_AW-1:0]    v_idx;
  logic                 b_ok, v_ok, bit_old;
  logic [CNT_W-1:0]     cnt_cur;
  logic [ROW_W-1:0]     ram_rdata, row_cur, row_new, v_onehot, vmask;
  logic                 mod_we, do_inc, do_dec, do_clr_bag, do_clr_all;
  logic [POP_W-1:0]     pop;
  logic [CNT_OUT_W-1:0] max_cnt;
  logic [TOTAL_OUT_W-1:0] total_sat;

  // Membership rows
  bvmt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_BAGS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (is_mod && mod_we),
    .waddr_i (b_idx),
    .wdata_i (row_new),
    .re_i    (ram_re),
    .raddr_i (BAG_AW'(in_i.bag_index)),
    .rdata_o (ram_rdata)
  );

  // Greatest count over vertices in use
  bvmt_max_tree #(
    .N  (MAX_VERTICES),
    .CW (CNT_W)
  ) u_max (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .counts_i (counts_q),
    .limit_i  (verts_q),
    .max_o    (max_cnt)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_MOD;
      S_MOD:  state_d = do_clr_bag ? S_CLR : S_WAIT;
      S_CLR:  if (chunk_q == CHK_W'(NCHUNK - 1)) state_d = S_WAIT;
      S_WAIT: if (wcnt_q == WAIT_W'(TREE_LVL)) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    is_mod   = 1'b0;
    is_clr   = 1'b0;
    is_wait  = 1'b0;
    is_done  = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_MOD:  is_mod   = 1'b1;
      S_CLR:  is_clr   = 1'b1;
      S_WAIT: is_wait  = 1'b1;
      S_DONE: is_done  = 1'b1;
      default: ;
    endcase
  end

  assign ram_re      = in_ready && in_i.valid;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_load    = is_done && out_free;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // Addressed row and vertex
  assign b_idx    = BAG_AW'(b_q);
  assign v_idx    = VTX_AW'(v_q);
  assign b_ok     = ({1'b0, b_q} < bags_q) && (int'(b_q) < MAX_BAGS);
  assign v_ok     = ({1'b0, v_q} < verts_q) && (int'(v_q) < MAX_VERTICES);
  assign row_cur  = valid_q[b_idx] ? ram_rdata : '0;
  assign bit_old  = row_cur[v_idx];
  assign cnt_cur  = counts_q[v_idx];
  assign v_onehot = ROW_W'(1) << v_idx;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      vmask[j] = (j < int'(verts_q));
    end
  end

  // Row modify and result fields
  always_comb begin
    row_new      = row_cur;
    mod_we       = 1'b0;
    do_inc       = 1'b0;
    do_dec       = 1'b0;
    do_clr_bag   = 1'b0;
    do_clr_all   = 1'b0;
    res_member_d = 1'b0;
    res_cnt_d    = '0;
    res_empty_d  = 1'b0;
    res_err_d    = 1'b0;
    unique case (op_q)
      OP_CLR_ALL: begin
        do_clr_all  = 1'b1;
        res_empty_d = 1'b1;
      end
      OP_CLR_BAG: begin
        if (!b_ok) begin
          res_err_d = 1'b1;
        end else begin
          do_clr_bag  = 1'b1;
          res_empty_d = 1'b1;
          if (v_ok) res_cnt_d = cnt_cur - CNT_W'(bit_old);
        end
      end
      // add, remove, query; unknown codes act as query
      default: begin
        if (!(b_ok && v_ok)) begin
          res_err_d = 1'b1;
        end else begin
          if (op_q == OP_ADD) begin
            row_new = row_cur | v_onehot;
            mod_we  = 1'b1;
            do_inc  = !bit_old;
          end else if (op_q == OP_REMOVE) begin
            row_new = row_cur & ~v_onehot;
            mod_we  = 1'b1;
            do_dec  = bit_old;
          end
          res_member_d = row_new[v_idx];
          res_cnt_d    = cnt_cur + CNT_W'(do_inc) - CNT_W'(do_dec);
          res_empty_d  = ~|(row_new & vmask);
        end
      end
    endcase
  end

  // Per-vertex counts and row valid bits
  always_comb begin
    valid_d = valid_q;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      counts_d[j] = counts_q[j];
    end
    if (is_mod) begin
      if (do_clr_all) begin
        valid_d = '0;
      end else if (do_clr_bag) begin
        valid_d[b_idx] = 1'b0;
      end else if (mod_we) begin
        valid_d[b_idx] = 1'b1;
      end
      for (int j = 0; j < MAX_VERTICES; j++) begin
        if (do_clr_all) begin
          counts_d[j] = '0;
        end else if (do_clr_bag) begin
          counts_d[j] = counts_q[j] - CNT_W'(row_cur[j]);
        end else if (VTX_AW'(j) == v_idx) begin
          counts_d[j] = counts_q[j] + CNT_W'(do_inc) - CNT_W'(do_dec);
        end
      end
    end
  end

  // Total of set bits; clear bag takes one chunk of the row per cycle
  assign pop = popcount_chunk(row_q[POP_CHUNK-1:0]);

  always_comb begin
    total_d = total_q;
    if (is_mod) begin
      if (do_clr_all) begin
        total_d = '0;
      end else begin
        total_d = total_q + TOT_W'(do_inc) - TOT_W'(do_dec);
      end
    end else if (is_clr) begin
      total_d = total_q - TOT_W'(pop);
    end
  end

  assign total_sat = (int'(total_q) > TOTAL_SAT) ? TOTAL_OUT_W'(TOTAL_SAT)
                                                 : TOTAL_OUT_W'(total_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bags_q      <= CFG_RESET;
      verts_q     <= CFG_RESET;
      valid_q     <= '0;
      total_q     <= '0;
      wcnt_q      <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
        counts_q[j] <= '0;
      end
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      counts_q <= counts_d;
      total_q  <= total_d;
      wcnt_q   <= is_wait ? wcnt_q + WAIT_W'(1) : '0;
      chunk_q  <= is_clr ? chunk_q + CHK_W'(1) : '0;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_BAGS_IN_USE:     bags_q  <= cfg_i.data;
          CFG_VERTICES_IN_USE: verts_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      op_q <= in_i.opcode;
      b_q  <= in_i.bag_index;
      v_q  <= in_i.vertex_index;
    end
    if (is_mod) begin
      res_member_q <= res_member_d;
      res_cnt_q    <= sat_cnt(res_cnt_d);
      res_empty_q  <= res_empty_d;
      res_err_q    <= res_err_d;
      row_q        <= ROW_PW'(row_cur);
    end else if (is_clr) begin
      row_q <= row_q >> POP_CHUNK;
    end
    if (out_load) begin
      out_o.member           <= res_member_q;
      out_o.vertex_bag_count <= res_cnt_q;
      out_o.bag_empty        <= res_empty_q;
      out_o.total_used       <= total_sat;
      out_o.max_bag_count    <= max_cnt;
      out_o.valid_res        <= (max_cnt <= CNT_OUT_W'(1));
      out_o.index_error      <= res_err_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // Checks
  `BVMT_ASSERT(a_accept_to_mod, (in_i.valid && in_i.ready) |=> (state_q == S_MOD), "transfer not followed by modify")
  `BVMT_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result loaded outside done")
  `BVMT_ASSERT(a_clr_all_empties, (is_mod && (op_q == OP_CLR_ALL)) |=> ((total_q == '0) && (valid_q == '0)), "clear all left state")
  `BVMT_ASSERT(a_add_sets_member, (is_mod && (op_q == OP_ADD) && !res_err_d) |=> res_member_q, "add did not set member")
  `BVMT_ASSERT_NEVER(a_clr_only_bag, is_clr && (op_q != OP_CLR_BAG), "popcount pass without clear bag")

endmodule
